// ----- src/rwe_pkg.sv -----
// Shared types and constants of the Ricker wavelet evaluator.
package rwe_pkg;

  // Fixed-point constants.
  localparam logic [31:0] TWO_PI_Q29         = 32'd3373259426;
  localparam logic [29:0] SQRTPI_HALF_Q30    = 30'd951578915;
  localparam logic [30:0] SQRTPI_PI_HALF_Q29 = 31'd1494736665;
  localparam logic [31:0] ONE_Q31            = 32'h8000_0000;
  localparam logic [28:0] X_LIMIT_Q24        = 29'd402653184;
  localparam logic [28:0] HALF_Q24           = 29'd8388608;
  localparam logic [28:0] ONEHALF_Q24        = 29'd25165824;

  // Shape of the exponential unit.
  localparam int unsigned HORNER_TERMS = 13;
  localparam int unsigned SQUARINGS    = 5;
  localparam int unsigned RECIP_SHIFT  = 35;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PEAK_FREQUENCY  = 2'd0;
  localparam logic [1:0] CFG_TIME_DELAY      = 2'd1;
  localparam logic [1:0] CFG_DERIVATIVE_MODE = 2'd2;

  // Data that rides alongside the exponential unit.
  typedef struct packed {
    logic [27:0] um;
    logic [28:0] x;
    logic        dneg;
    logic        zero;
  } rwe_side_t;

endpackage

// ----- src/rwe_front.sv -----
// Front stages: time offset, scaling by frequency, phase u and argument x.
module rwe_front #(
  parameter int TIME_FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       sample_time,
  input  logic [31:0]       peak_frequency,
  input  logic [31:0]       time_delay,
  output logic              out_valid,
  output rwe_pkg::rwe_side_t out_side
);

  localparam int SH = TIME_FRAC_BITS - 4;

  logic [6:0]  v_r;
  logic [32:0] s1_ad_r;
  logic        s1_dneg_r, s1_zero_r;
  logic [64:0] s2_prod_r;
  logic        s2_dneg_r, s2_zero_r;
  logic [24:0] s3_q_r;
  logic        s3_dneg_r, s3_zero_r;
  logic [56:0] s4_pm_r;
  logic        s4_dneg_r, s4_zero_r;
  logic [27:0] s5_um_r;
  logic        s5_dneg_r, s5_zero_r;
  logic [55:0] s6_sq_r;
  logic [27:0] s6_um_r;
  logic        s6_dneg_r, s6_zero_r;
  rwe_pkg::rwe_side_t s7_side_r;

  logic [32:0] d_nxt;
  logic [32:0] ad_nxt;
  logic [64:0] q_sum;
  logic [64:0] q_full;
  logic [56:0] um_sum;
  logic [56:0] x_sum;
  logic [30:0] x_full;

  // Valid bits follow the data through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // Offset from the centre time, kept as a magnitude and a sign.
  assign d_nxt  = {sample_time[31], sample_time} - {time_delay[31], time_delay};
  assign ad_nxt = d_nxt[32] ? (33'd0 - d_nxt) : d_nxt;

  // Rounded frequency times offset, in Q24.
  assign q_sum  = s2_prod_r + (65'd1 << (SH - 1));
  assign q_full = q_sum >> SH;

  // Rounding of u and of x.
  assign um_sum = s4_pm_r + (57'd1 << 28);
  assign x_sum  = {1'b0, s6_sq_r} + (57'd1 << 25);
  assign x_full = x_sum[56:26];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ad_r   <= ad_nxt;
      s1_dneg_r <= d_nxt[32];
      s1_zero_r <= sample_time[31] || (sample_time == 32'd0);

      s2_prod_r <= 65'(peak_frequency) * 65'(s1_ad_r);
      s2_dneg_r <= s1_dneg_r;
      s2_zero_r <= s1_zero_r;

      s3_q_r    <= q_full[24:0];
      s3_dneg_r <= s2_dneg_r;
      s3_zero_r <= s2_zero_r || (q_full[64:25] != '0);

      s4_pm_r   <= 57'(s3_q_r) * 57'(rwe_pkg::TWO_PI_Q29);
      s4_dneg_r <= s3_dneg_r;
      s4_zero_r <= s3_zero_r;

      s5_um_r   <= um_sum[56:29];
      s5_dneg_r <= s4_dneg_r;
      s5_zero_r <= s4_zero_r;

      s6_sq_r   <= 56'(s5_um_r) * 56'(s5_um_r);
      s6_um_r   <= s5_um_r;
      s6_dneg_r <= s5_dneg_r;
      s6_zero_r <= s5_zero_r;

      s7_side_r.um   <= s6_um_r;
      s7_side_r.x    <= x_full[28:0];
      s7_side_r.dneg <= s6_dneg_r;
      s7_side_r.zero <= s6_zero_r || (x_full > 31'(rwe_pkg::X_LIMIT_Q24));
    end
  end

  assign out_valid = v_r[6];
  assign out_side  = s7_side_r;

endmodule

// ----- src/rwe_exp.sv -----
// Pipelined exp(-x): Horner Taylor series in Q31, five squarings, rounding to Q24.
module rwe_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rwe_pkg::rwe_side_t in_side,
  output logic               out_valid,
  output rwe_pkg::rwe_side_t out_side,
  output logic [24:0]        out_e
);

  localparam int unsigned NT    = rwe_pkg::HORNER_TERMS;
  localparam int unsigned NS    = rwe_pkg::SQUARINGS;
  localparam int unsigned DEPTH = 3 * NT + 2 * NS + 1;

  logic [DEPTH-1:0]   vld_r;
  rwe_pkg::rwe_side_t side_r [DEPTH];

  logic [60:0] p_r  [NT];
  logic [31:0] tr_r [NT];
  logic [31:0] qd_r [NT];
  logic [31:0] h_r  [NT];
  logic [31:0] rin  [NT];
  logic [28:0] xin  [NT];

  logic [63:0] sq_r [NS];
  logic [31:0] sr_r [NS];
  logic [31:0] sin_w [NS];

  logic [24:0] e_r;
  logic [32:0] e_sum;

  // Valid bits and side data shift with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // One Horner step per term: multiply, round and divide, correct and subtract.
  for (genvar j = 0; j < NT; j++) begin : g_horner
    localparam int unsigned K = NT - j;
    localparam int unsigned RECIP_SHIFT_L = rwe_pkg::RECIP_SHIFT;
    localparam logic [35:0] RECIP = 36'((64'd1 << RECIP_SHIFT_L) / K);

    logic [60:0] pr_sum;
    logic [31:0] tr_nxt;
    logic [67:0] qm;
    logic [35:0] qk;
    logic [35:0] rem;
    logic [31:0] tq;

    if (j == 0) begin : g_first
      assign rin[j] = rwe_pkg::ONE_Q31;
      assign xin[j] = in_side.x;
    end else begin : g_next
      assign rin[j] = h_r[j-1];
      assign xin[j] = side_r[3*j-1].x;
    end

    assign pr_sum = p_r[j] + (61'd1 << 28);
    assign tr_nxt = pr_sum[60:29];
    assign qm     = 68'(tr_nxt) * 68'(RECIP);
    assign qk     = 36'(qd_r[j]) * 36'(K);
    assign rem    = 36'(tr_r[j]) - qk;
    assign tq     = (rem >= 36'(K)) ? (qd_r[j] + 32'd1) : qd_r[j];

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[j]  <= 61'(xin[j]) * 61'(rin[j]);
        tr_r[j] <= tr_nxt;
        qd_r[j] <= qm[RECIP_SHIFT_L+31:RECIP_SHIFT_L];
        h_r[j]  <= rwe_pkg::ONE_Q31 - tq;
      end
    end
  end

  // Repeated squaring undoes the division of the argument by 32.
  for (genvar i = 0; i < NS; i++) begin : g_square
    logic [63:0] sq_sum;

    if (i == 0) begin : g_first
      assign sin_w[i] = h_r[NT-1];
    end else begin : g_next
      assign sin_w[i] = sr_r[i-1];
    end

    assign sq_sum = sq_r[i] + (64'd1 << 30);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[i] <= 64'(sin_w[i]) * 64'(sin_w[i]);
        sr_r[i] <= sq_sum[62:31];
      end
    end
  end

  // Final rounding from Q31 to Q24.
  assign e_sum = {1'b0, sr_r[NS-1]} + 33'd64;

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_sum[31:7];
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_side  = side_r[DEPTH-1];
  assign out_e     = e_r;

endmodule

// ----- src/rwe_back.sv -----
// Back stages: wavelet or derivative polynomial, scaling, sign and saturation.
module rwe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rwe_pkg::rwe_side_t in_side,
  input  logic [24:0]        in_e,
  input  logic               derivative_mode,
  input  logic [31:0]        peak_frequency,
  output logic               out_valid,
  output logic [31:0]        out_amplitude,
  output logic               out_saturated
);

  logic [9:0]  v_r;
  logic [9:0]  sgn_r;
  logic [9:0]  zero_r;

  logic [28:0] b1_sm_r;
  logic [27:0] b1_um_r;
  logic [24:0] b1_e_r, b2_e_r, b3_e_r;
  logic [56:0] b2_p_r;
  logic [33:0] b3_a_r;
  logic [63:0] b4_p_r;
  logic [31:0] b5_v_r;
  logic [63:0] b6_p_r;
  logic [31:0] b7_b_r;
  logic [63:0] b8_p_r;
  logic [36:0] b9_m_r;
  logic [31:0] b10_amp_r;
  logic        b10_sat_r;

  logic        lo_half, hi_onehalf;
  logic [28:0] sm_nxt;
  logic        sgn_nxt;
  logic [27:0] op1;
  logic [57:0] a_sum;
  logic [29:0] op2;
  logic [64:0] s5_sum0, s5_sum1;
  logic [40:0] a1_full;
  logic [31:0] v5_nxt;
  logic [64:0] b_sum;
  logic [35:0] b_full;
  logic [31:0] b_nxt;
  logic [64:0] m_sum;
  logic [36:0] m_nxt;
  logic [31:0] amp_nxt;
  logic        sat_nxt;

  // Valid, sign and zero flags travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_r  <= {sgn_r[8:0], sgn_nxt};
      zero_r <= {zero_r[8:0], in_side.zero};
    end
  end

  // Distance of x from one half (wavelet) or from three halves (derivative).
  assign lo_half    = in_side.x < rwe_pkg::HALF_Q24;
  assign hi_onehalf = in_side.x > rwe_pkg::ONEHALF_Q24;

  always_comb begin
    if (derivative_mode) begin
      sm_nxt  = hi_onehalf ? (in_side.x - rwe_pkg::ONEHALF_Q24)
                           : (rwe_pkg::ONEHALF_Q24 - in_side.x);
      sgn_nxt = in_side.dneg ^ hi_onehalf;
    end else begin
      sm_nxt  = lo_half ? (rwe_pkg::HALF_Q24 - in_side.x)
                        : (in_side.x - rwe_pkg::HALF_Q24);
      sgn_nxt = lo_half;
    end
  end

  // Shared multipliers take their second operand by mode.
  assign op1     = derivative_mode ? b1_um_r : {3'b000, b1_e_r};
  assign a_sum   = {1'b0, b2_p_r} + (58'd1 << 23);
  assign op2     = derivative_mode ? {5'b00000, b3_e_r} : rwe_pkg::SQRTPI_HALF_Q30;

  assign s5_sum0 = {1'b0, b4_p_r} + (65'd1 << 37);
  assign s5_sum1 = {1'b0, b4_p_r} + (65'd1 << 23);
  assign a1_full = s5_sum1[64:24];
  always_comb begin
    if (derivative_mode) begin
      v5_nxt = (a1_full[40:32] != '0) ? 32'hFFFF_FFFF : a1_full[31:0];
    end else begin
      v5_nxt = {5'b00000, s5_sum0[64:38]};
    end
  end

  assign b_sum  = {1'b0, b6_p_r} + (65'd1 << 28);
  assign b_full = b_sum[64:29];
  always_comb begin
    if (derivative_mode) begin
      b_nxt = (b_full[35:32] != '0) ? 32'hFFFF_FFFF : b_full[31:0];
    end else begin
      b_nxt = b6_p_r[31:0];
    end
  end

  assign m_sum = {1'b0, b8_p_r} + (65'd1 << 27);
  assign m_nxt = derivative_mode ? m_sum[64:28] : {5'b00000, b8_p_r[31:0]};

  // Zeroing, sign application and clipping to the signed 32-bit range.
  always_comb begin
    amp_nxt = b9_m_r[31:0];
    sat_nxt = 1'b0;
    if (zero_r[8]) begin
      amp_nxt = 32'd0;
    end else if (sgn_r[8]) begin
      if (b9_m_r > 37'h0_8000_0000) begin
        amp_nxt = 32'h8000_0000;
        sat_nxt = 1'b1;
      end else begin
        amp_nxt = 32'd0 - b9_m_r[31:0];
      end
    end else if (b9_m_r > 37'h0_7FFF_FFFF) begin
      amp_nxt = 32'h7FFF_FFFF;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_sm_r   <= sm_nxt;
      b1_um_r   <= in_side.um;
      b1_e_r    <= in_e;
      b2_p_r    <= 57'(b1_sm_r) * 57'(op1);
      b2_e_r    <= b1_e_r;
      b3_a_r    <= a_sum[57:24];
      b3_e_r    <= b2_e_r;
      b4_p_r    <= 64'(b3_a_r) * 64'(op2);
      b5_v_r    <= v5_nxt;
      b6_p_r    <= derivative_mode ? 64'(b5_v_r) * 64'(rwe_pkg::SQRTPI_PI_HALF_Q29)
                                   : 64'(b5_v_r);
      b7_b_r    <= b_nxt;
      b8_p_r    <= derivative_mode ? 64'(b7_b_r) * 64'(peak_frequency) : 64'(b7_b_r);
      b9_m_r    <= m_nxt;
      b10_amp_r <= amp_nxt;
      b10_sat_r <= sat_nxt;
    end
  end

  assign out_valid     = v_r[9];
  assign out_amplitude = b10_amp_r;
  assign out_saturated = b10_sat_r;

endmodule

// ----- src/ricker_wavelet_evaluator_core.sv -----
// Top level of the Ricker wavelet evaluator: configuration, pipeline and output stage.
//
// Each request on the input channel carries one sample time (signed, TIME_FRAC_BITS
// fraction bits). The block returns one result per request, in order: the amplitude
// of the Ricker wavelet, or of its time derivative, in signed Q15.16, and a flag that
// marks a clipped value. Peak frequency, centre time and mode are set through the
// configuration channel, which is always ready; write it only while the block is idle.
// A request is taken when in_valid is high and in_stall low; a result is delivered
// when out_valid is high and out_stall low.
// The pipeline takes one request per clock cycle while it is not stalled. Most of the
// depth lies in the exponential unit: three stages for each of thirteen series terms
// and two for each of five squarings. A skid register behind the pipeline holds one
// result while the receiver stalls; the input stalls only while that register is full,
// and the whole pipeline then holds its contents. Reset empties the pipeline and loads
// the configuration with 10 Hz, zero delay and wavelet mode.
module ricker_wavelet_evaluator_core #(
  parameter int TIME_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_amplitude,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] peak_frequency_r;
  logic [31:0] time_delay_r;
  logic        derivative_mode_r;

  logic               en;
  logic               fr_valid;
  rwe_pkg::rwe_side_t fr_side;
  logic               ex_valid;
  rwe_pkg::rwe_side_t ex_side;
  logic [24:0]        ex_e;
  logic               bk_valid;
  logic [31:0]        bk_amp;
  logic               bk_sat;

  logic        out_valid_r;
  logic [31:0] out_amp_r;
  logic        out_sat_r;
  logic        skid_valid_r;
  logic [31:0] skid_amp_r;
  logic        skid_sat_r;
  logic        out_take;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_frequency_r  <= 32'd10485760;
      time_delay_r      <= 32'd0;
      derivative_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwe_pkg::CFG_PEAK_FREQUENCY:  peak_frequency_r  <= cfg_data;
        rwe_pkg::CFG_TIME_DELAY:      time_delay_r      <= cfg_data;
        rwe_pkg::CFG_DERIVATIVE_MODE: derivative_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the skid register is free.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  rwe_front #(
    .TIME_FRAC_BITS(TIME_FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .sample_time    (in_sample_time),
    .peak_frequency (peak_frequency_r),
    .time_delay     (time_delay_r),
    .out_valid      (fr_valid),
    .out_side       (fr_side)
  );

  rwe_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .out_valid (ex_valid),
    .out_side  (ex_side),
    .out_e     (ex_e)
  );

  rwe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (ex_valid),
    .in_side         (ex_side),
    .in_e            (ex_e),
    .derivative_mode (derivative_mode_r),
    .peak_frequency  (peak_frequency_r),
    .out_valid       (bk_valid),
    .out_amplitude   (bk_amp),
    .out_saturated   (bk_sat)
  );

  // Output register with a skid register behind it.
  assign out_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= bk_valid;
      end
    end else if (bk_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid_r) begin
        out_amp_r <= skid_amp_r;
        out_sat_r <= skid_sat_r;
      end else begin
        out_amp_r <= bk_amp;
        out_sat_r <= bk_sat;
      end
    end else if (!skid_valid_r) begin
      skid_amp_r <= bk_amp;
      skid_sat_r <= bk_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amp_r;
  assign out_saturated = out_sat_r;

endmodule

// ----- verif/tb_ricker_wavelet_evaluator_core.sv -----
// Self-checking testbench of the Ricker wavelet evaluator core.
module tb_ricker_wavelet_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TFB = 24;
  localparam int LATENCY = 67;
  localparam int N_RANDOM = 1950;
  localparam int CYCLE_LIMIT = 900000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_sample_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_amplitude;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ricker_wavelet_evaluator_core #(.TIME_FRAC_BITS(TFB)) u_top (.*);

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] amp;
    logic        sat;
  } wavelet_result_t;

  // Shadow copy of the configuration.
  logic [31:0] fc_reg;
  logic [31:0] t0_reg;
  logic        deriv_reg;

  wavelet_result_t expected_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          hold_off = 1'b0;

  function automatic logic [63:0] round_shift(logic [63:0] v, int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  // exp(-x) for x in Q24 by Horner series and repeated squaring, result in Q1.24.
  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = 64'(rwe_pkg::ONE_Q31);
    for (int k = rwe_pkg::HORNER_TERMS; k >= 1; k--) begin
      t = round_shift(x * r, 29) / k;
      r = 64'(rwe_pkg::ONE_Q31) - t;
    end
    for (int i = 0; i < rwe_pkg::SQUARINGS; i++) r = round_shift(r * r, 31);
    return round_shift(r, 7);
  endfunction

  // Predicts the amplitude and clip flag for one sample time.
  function automatic wavelet_result_t predict_wavelet(logic [31:0] st);
    wavelet_result_t res;
    logic signed [63:0] d;
    logic [63:0] ad, q, um, x, e, sm, a, b, mag;
    logic neg, wneg;
    res = '0;
    if ($signed(st) <= 0) return res;
    d = 64'(signed'(st)) - 64'(signed'(t0_reg));
    neg = d < 0;
    ad = neg ? 64'(-d) : 64'(d);
    q = round_shift(64'(fc_reg) * ad, TFB - 4);
    if (q >= (64'd1 << 25)) return res;
    um = round_shift(q * 64'(rwe_pkg::TWO_PI_Q29), 29);
    x = round_shift(um * um, 26);
    if (x > 64'(rwe_pkg::X_LIMIT_Q24)) return res;
    e = exp_neg(x);
    if (!deriv_reg) begin
      neg = x < 64'(rwe_pkg::HALF_Q24);
      sm = neg ? 64'(rwe_pkg::HALF_Q24) - x : x - 64'(rwe_pkg::HALF_Q24);
      a = round_shift(sm * e, 24);
      mag = round_shift(a * 64'(rwe_pkg::SQRTPI_HALF_Q30), 38);
    end else begin
      wneg = x > 64'(rwe_pkg::ONEHALF_Q24);
      sm = wneg ? x - 64'(rwe_pkg::ONEHALF_Q24) : 64'(rwe_pkg::ONEHALF_Q24) - x;
      neg = neg != wneg;
      a = round_shift(um * sm, 24);
      a = round_shift(a * e, 24);
      if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
      b = round_shift(a * 64'(rwe_pkg::SQRTPI_PI_HALF_Q29), 29);
      if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
      mag = round_shift(b * 64'(fc_reg), 28);
    end
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        res.sat = 1'b1;
      end
      res.amp = 32'(64'h1_0000_0000 - mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        mag = 64'h7FFF_FFFF;
        res.sat = 1'b1;
      end
      res.amp = mag[31:0];
    end
    return res;
  endfunction

  // Idle gap length: mostly short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Directed stimulus: time, with an expected result typed in where obvious.
  typedef struct {
    logic [31:0]     st;
    bit              known;
    wavelet_result_t res;
  } directed_row_t;

  directed_row_t directed_tbl[] = '{
    '{32'h0000_0000, 1'b1, '{32'h0, 1'b0}},
    '{32'h8000_0000, 1'b1, '{32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b1, '{32'h0, 1'b0}},
    '{32'h0000_0001, 1'b0, '{32'h0, 1'b0}},
    '{32'h0040_0000, 1'b0, '{32'h0, 1'b0}},
    '{32'h0080_0000, 1'b0, '{32'h0, 1'b0}},
    '{32'h0100_0000, 1'b0, '{32'h0, 1'b0}},
    '{32'h0020_0000, 1'b0, '{32'h0, 1'b0}},
    '{32'h0002_8F5C, 1'b0, '{32'h0, 1'b0}},
    '{32'h0033_3333, 1'b0, '{32'h0, 1'b0}},
    '{32'h5555_5555, 1'b0, '{32'h0, 1'b0}}
  };

  // Sends one request and queues its expected result; valid stays up when no gap follows.
  task automatic send_sample(logic [31:0] st, bit known, wavelet_result_t res);
    int n;
    in_valid <= 1'b1;
    in_sample_time <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(known ? res : predict_wavelet(st));
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits until every expected result is back plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      rwe_pkg::CFG_PEAK_FREQUENCY:  fc_reg = val;
      rwe_pkg::CFG_TIME_DELAY:      t0_reg = val;
      rwe_pkg::CFG_DERIVATIVE_MODE: deriv_reg = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random sample time spread over the interesting window around the centre.
  function automatic logic [31:0] rand_time();
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) return $urandom();
    if (p < 15) return 32'($urandom_range(0, 3)) - 32'd1;
    return 32'(signed'(t0_reg) + $signed(32'($urandom_range(0, 32'h0080_0000)))
               - 32'sh0040_0000);
  endfunction

  // Random receiver stalls, with one long hold-off.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        n = gap_len();
        out_stall <= (n != 0);
        repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    wavelet_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result amp=%h sat=%b",
                                       out_amplitude, out_saturated);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.amp !== out_amplitude || exp_r.sat !== out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected amp=%h sat=%b, got amp=%h sat=%b",
                     exp_r.amp, exp_r.sat, out_amplitude, out_saturated);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ricker_wavelet_evaluator_core: FAIL");
      $finish;
    end
  end

  // Settings walked by the random phases: frequency, delay, mode.
  logic [31:0] phase_fc[] = '{32'd10485760, 32'd31457280, 32'hFFFF_FFFF, 32'd0,
                             32'd1048576, 32'd52428800, 32'd10485760, 32'd20971520};
  logic [31:0] phase_t0[] = '{32'h0100_0000, 32'h0180_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h0400_0000, 32'h0060_0000,
                             32'h0000_0000, 32'h0200_0000};

  initial begin
    wavelet_result_t none;
    none = '0;
    fc_reg = 32'd10485760;
    t0_reg = '0;
    deriv_reg = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part in both modes.
    for (int m = 0; m < 2; m++) begin
      write_cfg(rwe_pkg::CFG_DERIVATIVE_MODE, 32'(m));
      write_cfg(rwe_pkg::CFG_TIME_DELAY, 32'h0080_0000);
      foreach (directed_tbl[i])
        send_sample(directed_tbl[i].st, directed_tbl[i].known, directed_tbl[i].res);
      drain();
    end

    // Overflow: the largest frequency in derivative mode near the centre.
    write_cfg(rwe_pkg::CFG_PEAK_FREQUENCY, 32'hFFFF_FFFF);
    send_sample(32'h0080_0001, 1'b0, none);
    send_sample(32'h007F_FFFF, 1'b0, none);
    drain();

    // Random phases over several settings; one long receiver hold-off.
    for (int ph = 0; ph < 2 * phase_fc.size(); ph++) begin
      write_cfg(rwe_pkg::CFG_PEAK_FREQUENCY, phase_fc[ph % phase_fc.size()]);
      write_cfg(rwe_pkg::CFG_TIME_DELAY, phase_t0[ph % phase_t0.size()]);
      write_cfg(rwe_pkg::CFG_DERIVATIVE_MODE, 32'(ph & 1));
      if (ph == 3) hold_off = 1'b1;
      for (int i = 0; i < N_RANDOM / 16; i++) begin
        if (ph == 3) begin
          in_valid <= 1'b1;
          in_sample_time <= rand_time();
          @(posedge clk);
          while (in_stall) @(posedge clk);
          expected_q.push_back(predict_wavelet(in_sample_time));
        end else begin
          send_sample(rand_time(), 1'b0, none);
        end
      end
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_ricker_wavelet_evaluator_core: PASS");
    end else begin
      $display("tb_ricker_wavelet_evaluator_core: FAIL");
    end
    $finish;
  end

endmodule
